### rtl/core/gnds_pkg.sv
// Shared types, codes and strength arithmetic for the node degree/strength accumulator.
`timescale 1ns / 1ps
`default_nettype none

package gnds_pkg;

  localparam int unsigned OP_W         = 2;
  localparam int unsigned ID_W         = 16;
  localparam int unsigned WEIGHT_W     = 32;
  localparam int unsigned STRENGTH_W   = 48;
  localparam int unsigned DEG_OUT_W    = 24;
  localparam int unsigned NODE_COUNT_W = 17;

  localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
  localparam logic [OP_W-1:0] OP_READ     = 2'd1;
  localparam logic [OP_W-1:0] OP_READ_CLR = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST = 17'h10000;

  localparam logic signed [STRENGTH_W-1:0] STRENGTH_MAX = {1'b0, {(STRENGTH_W-1){1'b1}}};
  localparam logic signed [STRENGTH_W-1:0] STRENGTH_MIN = {1'b1, {(STRENGTH_W-1){1'b0}}};

  typedef logic signed [STRENGTH_W-1:0] strength_t;
  typedef logic signed [WEIGHT_W-1:0]   weight_t;

  // Saturating strength + weight.
  function automatic strength_t strength_add(input strength_t s, input weight_t w);
    logic signed [STRENGTH_W:0] sum;
    strength_t res;
    sum = {s[STRENGTH_W-1], s} + {{(STRENGTH_W-WEIGHT_W+1){w[WEIGHT_W-1]}}, w};
    if (sum[STRENGTH_W] != sum[STRENGTH_W-1]) begin
      res = sum[STRENGTH_W] ? STRENGTH_MIN : STRENGTH_MAX;
    end else begin
      res = sum[STRENGTH_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/core/graph_node_degree_strength_accumulator.sv
// Top level: per-node degree and strength accumulator over an undirected weighted edge stream.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a saturating degree and a saturating signed Q32.16 strength for each
// of MAX_NODES nodes in two synchronous memories sharing one read port and
// one write port. An in-range add request passes through states P1 and P2
// (read-modify-write of the source entry, then of the target entry, both
// through the single read port); a read or read-clear request, a rejected
// request and an unused operation finish in P1. The next request is taken
// in the cycle a result leaves for the output register, so reads sustain
// one per cycle while the output side keeps up. After reset a clearing
// pass zeroes both memories; no request is taken during it, configuration
// writes are. Each request returns exactly one result: adds return zero degree
// and strength, with the OK status if in range and the range status if not.
module graph_node_degree_strength_accumulator #(
  parameter int unsigned MAX_NODES   = 65536,
  parameter int unsigned DEGREE_BITS = 24
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,

  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [gnds_pkg::NODE_COUNT_W-1:0]   cfg_data_i,

  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [gnds_pkg::OP_W-1:0]           operation_i,
  input  wire logic [gnds_pkg::ID_W-1:0]           source_node_i,
  input  wire logic [gnds_pkg::ID_W-1:0]           target_node_i,
  input  wire logic signed [gnds_pkg::WEIGHT_W-1:0] edge_weight_i,

  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [gnds_pkg::DEG_OUT_W-1:0]           node_degree_o,
  output logic signed [gnds_pkg::STRENGTH_W-1:0]   node_strength_o,
  output logic                                     status_o
);

  localparam int unsigned AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned MNW = $clog2(MAX_NODES + 1);
  localparam int unsigned LW  = (MNW > gnds_pkg::NODE_COUNT_W) ? MNW : gnds_pkg::NODE_COUNT_W;
  localparam int unsigned DB  = DEGREE_BITS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_NODES - 1);
  localparam logic [LW-1:0] MAX_LIMIT = LW'(MAX_NODES);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_P1,
    S_P2
  } state_e;

  // Storage
  logic [DB-1:0]           deg_mem [MAX_NODES];
  gnds_pkg::strength_t     str_mem [MAX_NODES];
  logic [DB-1:0]           rd_deg_q;
  gnds_pkg::strength_t     rd_str_q;
  logic [AW-1:0]           rd_addr_q;

  // Control and request registers
  state_e                         state_q;
  logic [AW-1:0]                  clr_cnt_q;
  logic [gnds_pkg::NODE_COUNT_W-1:0] node_count_q;
  logic [gnds_pkg::OP_W-1:0]      op_q;
  logic [AW-1:0]                  src_q;
  logic [AW-1:0]                  dst_q;
  gnds_pkg::weight_t              wgt_q;
  logic                           ok_q;
  logic                           out_valid_q;
  logic [gnds_pkg::DEG_OUT_W-1:0] out_deg_q;
  gnds_pkg::strength_t            out_str_q;
  logic                           out_status_q;

  // Last memory write, for read-after-write forwarding
  logic                    last_vld_q;
  logic [AW-1:0]           last_addr_q;
  logic [DB-1:0]           last_deg_q;
  gnds_pkg::strength_t     last_str_q;

  logic                    accept;
  logic                    add_ok;
  logic                    finishing;
  logic                    out_free;
  logic                    leave;
  logic [LW-1:0]           limit;
  logic [LW-1:0]           in_src_ext;
  logic [LW-1:0]           in_dst_ext;
  logic                    in_src_ok;
  logic                    in_dst_ok;
  logic                    in_ok;
  logic                    mem_re;
  logic [AW-1:0]           rd_addr;
  logic                    mem_we;
  logic [AW-1:0]           wr_addr;
  logic [DB-1:0]           wr_deg;
  gnds_pkg::strength_t     wr_str;
  logic                    fwd;
  logic [DB-1:0]           cur_deg;
  gnds_pkg::strength_t     cur_str;
  logic [DB-1:0]           new_deg;
  gnds_pkg::strength_t     new_str;
  logic [32:0]             cur_deg_ext;
  logic [gnds_pkg::DEG_OUT_W-1:0] cur_deg_out;
  logic [gnds_pkg::DEG_OUT_W-1:0] res_deg;
  gnds_pkg::strength_t     res_str;
  logic                    res_status;

  assign cfg_ready_o = 1'b1;

  // Effective node count: clamp to the store depth
  always_comb begin
    limit = {{(LW-gnds_pkg::NODE_COUNT_W){1'b0}}, node_count_q};
    if (limit > MAX_LIMIT) begin
      limit = MAX_LIMIT;
    end
  end

  assign in_src_ext = {{(LW-gnds_pkg::ID_W){1'b0}}, source_node_i};
  assign in_dst_ext = {{(LW-gnds_pkg::ID_W){1'b0}}, target_node_i};
  assign in_src_ok  = in_src_ext < limit;
  assign in_dst_ok  = in_dst_ext < limit;

  always_comb begin
    unique case (operation_i)
      gnds_pkg::OP_ADD:      in_ok = in_src_ok && in_dst_ok;
      gnds_pkg::OP_READ,
      gnds_pkg::OP_READ_CLR: in_ok = in_src_ok;
      default:               in_ok = 1'b1;
    endcase
  end

  assign add_ok    = (op_q == gnds_pkg::OP_ADD) && ok_q;
  assign finishing = ((state_q == S_P1) && !add_ok) || (state_q == S_P2);
  assign out_free  = !out_valid_q || out_ready_i;
  assign leave     = finishing && out_free;
  assign in_ready_o = (state_q == S_IDLE) || leave;
  assign accept    = in_valid_i && in_ready_o;

  // Read port: source on accept, target in state P1 of an in-range add
  assign mem_re  = accept || ((state_q == S_P1) && add_ok);
  assign rd_addr = accept ? in_src_ext[AW-1:0] : dst_q;

  // Entry as it stands now: memory data, or the write that raced the read
  assign fwd     = last_vld_q && (last_addr_q == rd_addr_q);
  assign cur_deg = fwd ? last_deg_q : rd_deg_q;
  assign cur_str = fwd ? last_str_q : rd_str_q;
  assign new_deg = (cur_deg == {DB{1'b1}}) ? cur_deg : cur_deg + DB'(1);
  assign new_str = gnds_pkg::strength_add(cur_str, wgt_q);

  assign cur_deg_ext = {{(33-DB){1'b0}}, cur_deg};
  assign cur_deg_out = (cur_deg_ext > {9'd0, {gnds_pkg::DEG_OUT_W{1'b1}}}) ?
                       {gnds_pkg::DEG_OUT_W{1'b1}} : cur_deg_ext[gnds_pkg::DEG_OUT_W-1:0];

  // Write port
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = src_q;
    wr_deg  = '0;
    wr_str  = '0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_cnt_q;
      end
      S_P1: begin
        if (add_ok) begin
          mem_we = 1'b1;
          wr_deg = new_deg;
          wr_str = new_str;
        end else if (leave && ok_q && (op_q == gnds_pkg::OP_READ_CLR)) begin
          mem_we = 1'b1;
        end
      end
      S_P2: begin
        if (leave) begin
          mem_we  = 1'b1;
          wr_addr = dst_q;
          wr_deg  = new_deg;
          wr_str  = new_str;
        end
      end
      default: ;
    endcase
  end

  // Result of the finishing request
  always_comb begin
    res_deg    = '0;
    res_str    = '0;
    res_status = gnds_pkg::STATUS_OK;
    if (state_q == S_P1) begin
      unique case (op_q)
        gnds_pkg::OP_ADD: res_status = gnds_pkg::STATUS_RANGE;  // only rejected adds end here
        gnds_pkg::OP_READ,
        gnds_pkg::OP_READ_CLR: begin
          if (ok_q) begin
            res_deg = cur_deg_out;
            res_str = cur_str;
          end else begin
            res_status = gnds_pkg::STATUS_RANGE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      deg_mem[wr_addr] <= wr_deg;
      str_mem[wr_addr] <= wr_str;
    end
    if (mem_re) begin
      rd_deg_q  <= deg_mem[rd_addr];
      rd_str_q  <= str_mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_cnt_q    <= '0;
      node_count_q <= gnds_pkg::NODE_COUNT_RST;
      out_valid_q  <= 1'b0;
      last_vld_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        node_count_q <= cfg_data_i;
      end

      if (mem_we) begin
        last_vld_q  <= 1'b1;
        last_addr_q <= wr_addr;
        last_deg_q  <= wr_deg;
        last_str_q  <= wr_str;
      end

      if (accept) begin
        op_q  <= operation_i;
        src_q <= in_src_ext[AW-1:0];
        dst_q <= in_dst_ext[AW-1:0];
        wgt_q <= edge_weight_i;
        ok_q  <= in_ok;
      end

      if (leave) begin
        out_valid_q  <= 1'b1;
        out_deg_q    <= res_deg;
        out_str_q    <= res_str;
        out_status_q <= res_status;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_cnt_q == LAST_ADDR) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_q <= S_P1;
          end
        end
        S_P1: begin
          if (add_ok) begin
            state_q <= S_P2;
          end else if (leave) begin
            state_q <= accept ? S_P1 : S_IDLE;
          end
        end
        S_P2: begin
          if (leave) begin
            state_q <= accept ? S_P1 : S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign node_degree_o   = out_deg_q;
  assign node_strength_o = out_str_q;
  assign status_o        = out_status_q;

`ifndef NO_ASSERTIONS
  a_no_request_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_ready_o)
    else $error("request taken during clearing pass");

  a_reject_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_P1) && !ok_q) |-> !mem_we)
    else $error("rejected request wrote the store");

  a_add_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_P2) && out_free) |=>
      (out_valid_o && (status_o == gnds_pkg::STATUS_OK) && (node_degree_o == '0)))
    else $error("add result missing or malformed");
`endif

endmodule

`default_nettype wire
